/* hdl/rgbm_pkg.sv */
// ----------------------------------------------------------------------------
// rgbm_pkg: shared types and constants of the RGB 3x3 median filter
// Pixel and result item layouts, configuration register indexes and the
// sizing of the output queue.
// ----------------------------------------------------------------------------
package rgbm_pkg;

	// One raster pixel as it arrives on the input channel.
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	// One filtered result item.
	typedef struct packed {
		logic [7:0]  median_red;
		logic [7:0]  median_green;
		logic [7:0]  median_blue;
		logic [11:0] center_row;
		logic [9:0]  center_col;
		logic        frame_last;
	} res_out_t;

	// Coordinates and frame mark that travel alongside the medians.
	typedef struct packed {
		logic [11:0] center_row;
		logic [9:0]  center_col;
		logic        frame_last;
	} res_meta_t;

	// Nine samples of one colour channel.
	typedef logic [8:0][7:0] chan_win_t;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 4'd0,
		REG_IMAGE_HEIGHT = 4'd1
	} cfg_reg_t;

	// Output queue sizing; it must exceed the pipeline latency for full rate.
	localparam int unsigned RES_FIFO_DEPTH = 8;
	localparam int unsigned RES_PTR_W      = 3;
	localparam int unsigned RES_CNT_W      = 4;

endpackage

/* hdl/rgbm_line_store.sv */
// ----------------------------------------------------------------------------
// rgbm_line_store: one row of pixels
// Single-port-write, single-port-read memory with a registered read, holding
// one raster line of RGB pixels.
// ----------------------------------------------------------------------------
module rgbm_line_store #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  rgbm_pkg::pix_in_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output rgbm_pkg::pix_in_t rd_data
);
	import rgbm_pkg::*;

	pix_in_t mem [DEPTH];
	pix_in_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/rgbm_lane.sv */
// ----------------------------------------------------------------------------
// rgbm_lane: median of nine samples for one colour channel
// Three-stage pipeline: sort each row of three, then take the largest
// minimum, the median of medians and the smallest maximum, then the median
// of those three values.
// ----------------------------------------------------------------------------
module rgbm_lane (
	input  logic                clk,
	input  rgbm_pkg::chan_win_t window,
	output logic [7:0]          median
);
	import rgbm_pkg::*;

	logic [2:0][7:0] row_min_s3;
	logic [2:0][7:0] row_med_s3;
	logic [2:0][7:0] row_max_s3;
	logic [7:0]      lo_s4;
	logic [7:0]      mid_s4;
	logic [7:0]      hi_s4;
	logic [7:0]      median_s5;

	function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return min2(min2(a, b), c);
	endfunction

	function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return max2(max2(a, b), c);
	endfunction

	function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// First stage: order the three samples of each window row.
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			row_min_s3[r] <= min3(window[3*r], window[3*r+1], window[3*r+2]);
			row_med_s3[r] <= med3(window[3*r], window[3*r+1], window[3*r+2]);
			row_max_s3[r] <= max3(window[3*r], window[3*r+1], window[3*r+2]);
		end
	end

	// Second stage: the median lies between these three candidates.
	always_ff @(posedge clk) begin
		lo_s4  <= max3(row_min_s3[0], row_min_s3[1], row_min_s3[2]);
		mid_s4 <= med3(row_med_s3[0], row_med_s3[1], row_med_s3[2]);
		hi_s4  <= min3(row_max_s3[0], row_max_s3[1], row_max_s3[2]);
	end

	// Third stage: the median of the candidates is the median of all nine.
	always_ff @(posedge clk) begin
		median_s5 <= med3(lo_s4, mid_s4, hi_s4);
	end

	assign median = median_s5;

endmodule

/* hdl/rgbm_merge.sv */
// ----------------------------------------------------------------------------
// rgbm_merge: result assembly and output queue
// Joins the three channel medians with the centre coordinates into one
// result item and buffers it in a small queue towards the output channel.
// ----------------------------------------------------------------------------
module rgbm_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  logic [7:0]          med_red,
	input  logic [7:0]          med_green,
	input  logic [7:0]          med_blue,
	input  rgbm_pkg::res_meta_t meta,
	output logic                out_valid,
	input  logic                out_ready,
	output rgbm_pkg::res_out_t  out_data
);
	import rgbm_pkg::*;

	res_out_t               fifo_q [RES_FIFO_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   fifo_cnt_q;
	res_out_t               res_item;
	logic                   rd_take;

	// Pack the lane results and the coordinates into one item.
	always_comb begin
		res_item.median_red   = med_red;
		res_item.median_green = med_green;
		res_item.median_blue  = med_blue;
		res_item.center_row   = meta.center_row;
		res_item.center_col   = meta.center_col;
		res_item.frame_last   = meta.frame_last;
	end

	assign rd_take   = out_valid && out_ready;
	assign out_valid = (fifo_cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			fifo_q[wr_ptr_q] <= res_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (rd_take) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			case ({wr_valid, rd_take})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + RES_CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - RES_CNT_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	// The input-side credit count must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> (fifo_cnt_q < RES_CNT_W'(RES_FIFO_DEPTH)))
		else $error("result written into a full queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= RES_CNT_W'(RES_FIFO_DEPTH))
		else $error("queue fill level out of range");

endmodule

/* hdl/rgb_median_filter_3x3.sv */
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3: 3x3 median filter on an RGB raster stream
// Line stores, sliding window, one median lane per colour channel and an
// output queue.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock cycle in raster order and, for every
// pixel that completes a full 3x3 neighbourhood, delivers the median of each
// colour channel with the coordinates of the centre pixel; border pixels give
// no result. The input is held off only when the eight-entry output queue,
// counting results still in the pipeline, is full, so the sustained rate is
// one pixel per cycle for as long as the output side takes one result per
// cycle. Frame size must be set through the configuration port only while
// the filter is idle; the block does not enforce this. Values out of range
// (the width taken from the low 11 bits) are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT. The line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3 #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rgbm_pkg::pix_in_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rgbm_pkg::res_out_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rgbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rgbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rgbm_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	localparam int unsigned RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int unsigned RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// Configuration, held as last column and last row indexes.
	logic [COL_W-1:0] last_col_q;
	logic [ROW_W-1:0] last_row_q;
	logic [31:0]      cfg_w;
	logic [31:0]      cfg_h;
	logic [COL_W-1:0] last_col_d;
	logic [ROW_W-1:0] last_row_d;

	// Raster position.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             at_last_col;
	logic             at_last_row;
	logic             emit;
	res_meta_t        meta_d;

	// Pipeline.
	pix_in_t          pix_s1;
	logic [COL_W-1:0] addr_s1;
	logic             pix_valid_s1;
	res_meta_t        meta_s1;
	res_meta_t        meta_s2;
	res_meta_t        meta_s3;
	res_meta_t        meta_s4;
	res_meta_t        meta_s5;
	logic             res_valid_s1;
	logic             res_valid_s2;
	logic             res_valid_s3;
	logic             res_valid_s4;
	logic             res_valid_s5;
	pix_in_t          top_rd;
	pix_in_t          mid_rd;
	pix_in_t          window_q [9];
	chan_win_t        red_win;
	chan_win_t        green_win;
	chan_win_t        blue_win;
	logic [7:0]       med_red;
	logic [7:0]       med_green;
	logic [7:0]       med_blue;

	// Output credit count: results in flight plus results queued.
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic                 res_take;

	// Clamp a written frame size and turn it into a last index.
	assign cfg_ready = 1'b1;
	assign cfg_w     = 32'(cfg_data[10:0]);
	assign cfg_h     = 32'(cfg_data[12:0]);

	always_comb begin
		if (cfg_w < 32'd3) begin
			last_col_d = COL_W'(2);
		end else if (cfg_w > 32'(MAX_WIDTH)) begin
			last_col_d = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col_d = COL_W'(cfg_w - 32'd1);
		end
		if (cfg_h < 32'd3) begin
			last_row_d = ROW_W'(2);
		end else if (cfg_h > 32'(MAX_HEIGHT)) begin
			last_row_d = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			last_row_d = ROW_W'(cfg_h - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(RST_W - 1);
			last_row_q <= ROW_W'(RST_H - 1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  last_col_q <= last_col_d;
				REG_IMAGE_HEIGHT: last_row_q <= last_row_d;
				default:          ;
			endcase
		end
	end

	// Position of the incoming pixel and what its result will carry.
	assign in_ready    = (res_cnt_q < RES_CNT_W'(RES_FIFO_DEPTH));
	assign accept      = in_valid && in_ready;
	assign at_last_col = (col_q >= last_col_q);
	assign at_last_row = (row_q >= last_row_q);
	assign emit        = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	always_comb begin
		meta_d.center_row = 12'(row_q - ROW_W'(1));
		meta_d.center_col = 10'(col_q - COL_W'(1));
		meta_d.frame_last = at_last_col && at_last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Line stores: read at acceptance, written back in the next cycle.
	rgbm_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_store_upper (
		.clk     (clk),
		.wr_en   (pix_valid_s1),
		.wr_addr (addr_s1),
		.wr_data (mid_rd),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (top_rd)
	);

	rgbm_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_store_middle (
		.clk     (clk),
		.wr_en   (pix_valid_s1),
		.wr_addr (addr_s1),
		.wr_data (pix_s1),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// First stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= in_data;
			addr_s1 <= col_q;
			meta_s1 <= meta_d;
		end
	end

	// Sliding window: columns move left, the new column enters at the right.
	always_ff @(posedge clk) begin
		if (pix_valid_s1) begin
			window_q[0] <= window_q[1];
			window_q[1] <= window_q[2];
			window_q[2] <= top_rd;
			window_q[3] <= window_q[4];
			window_q[4] <= window_q[5];
			window_q[5] <= mid_rd;
			window_q[6] <= window_q[7];
			window_q[7] <= window_q[8];
			window_q[8] <= pix_s1;
		end
	end

	// Coordinates follow the lanes stage by stage.
	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		meta_s5 <= meta_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			res_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
			res_valid_s3 <= 1'b0;
			res_valid_s4 <= 1'b0;
			res_valid_s5 <= 1'b0;
		end else begin
			pix_valid_s1 <= accept;
			res_valid_s1 <= accept && emit;
			res_valid_s2 <= res_valid_s1;
			res_valid_s3 <= res_valid_s2;
			res_valid_s4 <= res_valid_s3;
			res_valid_s5 <= res_valid_s4;
		end
	end

	// Split the window into its three colour channels.
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			red_win[i]   = window_q[i].red_in;
			green_win[i] = window_q[i].green_in;
			blue_win[i]  = window_q[i].blue_in;
		end
	end

	rgbm_lane u_lane_red (
		.clk    (clk),
		.window (red_win),
		.median (med_red)
	);

	rgbm_lane u_lane_green (
		.clk    (clk),
		.window (green_win),
		.median (med_green)
	);

	rgbm_lane u_lane_blue (
		.clk    (clk),
		.window (blue_win),
		.median (med_blue)
	);

	rgbm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (res_valid_s5),
		.med_red   (med_red),
		.med_green (med_green),
		.med_blue  (med_blue),
		.meta      (meta_s5),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Credits: taken when a result-producing pixel enters, returned on output.
	assign res_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
		end else begin
			case ({accept && emit, res_take})
				2'b10:   res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
				2'b01:   res_cnt_q <= res_cnt_q - RES_CNT_W'(1);
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	// An interior pixel reaches the output queue a fixed time after entry.
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |-> ##5 res_valid_s5)
		else $error("result did not reach the output queue on time");

	// The credit count never exceeds the queue depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RES_CNT_W'(RES_FIFO_DEPTH))
		else $error("credit count out of range");

	// Write-back and the next read never hit the same line store entry.
	a_no_store_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid_s1 |-> (addr_s1 != col_q))
		else $error("line store read and write-back collide");

endmodule
